/* hdl/wlrr_pkg.sv */
// wlrr_pkg: shared constants, codes and types for the wear-levelled record ring.
// Used by the channel interfaces, the byte store and the top level; depends on nothing.
package wlrr_pkg;

    localparam int RECORD_SLOTS_DEF = 21;
    localparam int STORE_BYTES_DEF  = 128;

    // byte address into the store; holds every slot and count-area address
    localparam int ADDR_W = 8;
    // width of a record count as carried on the result channel
    localparam int TOTAL_W = 5;

    localparam logic [7:0] ERASED_BYTE = 8'hFE;
    // an erase leaves bytes from this address upwards untouched
    localparam int WRITABLE_LIMIT = 250;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_ERASE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_WRITTEN    = 3'd0,
        ST_RECORD     = 3'd1,
        ST_COUNT      = 3'd2,
        ST_NO_SAMPLES = 3'd3,
        ST_ERASED     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FETCH,
        S_EMIT
    } state_t;

    // write side of the byte store
    typedef struct packed {
        logic              wr_en;
        logic              erase;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

endpackage

/* hdl/wlrr_cmd_if.sv */
// wlrr_cmd_if: command channel of the record ring (valid/ready plus command fields).
// Depends on wlrr_pkg.
interface wlrr_cmd_if;
    logic                     valid;
    logic                     ready;
    wlrr_pkg::action_t        action;
    logic signed [15:0]       temperature_tenths;
    logic signed [15:0]       pressure_tenths;
    logic [7:0]               sample_count;

    modport source (output valid, action, temperature_tenths, pressure_tenths, sample_count,
                    input ready);
    modport sink   (input valid, action, temperature_tenths, pressure_tenths, sample_count,
                    output ready);
endinterface

/* hdl/wlrr_rsp_if.sv */
// wlrr_rsp_if: result channel of the record ring (valid/ready plus result fields).
// Depends on wlrr_pkg.
interface wlrr_rsp_if;
    logic                             valid;
    logic                             ready;
    wlrr_pkg::status_t                status;
    logic signed [15:0]               temperature_out;
    logic signed [15:0]               pressure_out;
    logic [wlrr_pkg::TOTAL_W-1:0]     stored_total;
    logic                             last;

    modport source (output valid, status, temperature_out, pressure_out, stored_total, last,
                    input ready);
    modport sink   (input valid, status, temperature_out, pressure_out, stored_total, last,
                    output ready);
endinterface

/* hdl/wlrr_store.sv */
// wlrr_store: byte store, synchronous RAM with registered read and per-byte
// valid flags so that unwritten or erased bytes read as the erased value. Uses wlrr_pkg.
module wlrr_store #(
    parameter int STORE_BYTES = wlrr_pkg::STORE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wlrr_pkg::ADDR_W-1:0]   rd_addr,
    output logic [7:0]                    rd_data,
    input  wlrr_pkg::store_wr_t           wr
);

    localparam int IW = $clog2(STORE_BYTES);
    localparam logic [wlrr_pkg::ADDR_W:0] STORE_LIM = STORE_BYTES[wlrr_pkg::ADDR_W:0];

    logic [7:0]             mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] valid_reg;
    logic [7:0]             rd_byte_reg;
    logic                   rd_ok_reg;
    logic                   rd_in;
    logic                   wr_in;
    logic [IW-1:0]          rd_idx;
    logic [IW-1:0]          wr_idx;

    // addresses past the end of the store read erased and drop writes
    assign rd_in  = {1'b0, rd_addr} < STORE_LIM;
    assign wr_in  = {1'b0, wr.addr} < STORE_LIM;
    assign rd_idx = rd_addr[IW-1:0];
    assign wr_idx = wr.addr[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.wr_en && wr_in)
        begin
            mem[wr_idx] <= wr.data;
        end
        rd_byte_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= rd_in && valid_reg[rd_idx];
            if (wr.erase)
            begin
                for (int a = 0; a < STORE_BYTES; a++)
                begin
                    if (a < wlrr_pkg::WRITABLE_LIMIT)
                    begin
                        valid_reg[a] <= 1'b0;
                    end
                end
            end
            else if (wr.wr_en && wr_in)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_byte_reg : wlrr_pkg::ERASED_BYTE;

endmodule

/* hdl/wear_leveled_record_ring_unit.sv */
// wear_leveled_record_ring_unit: top level of the wear-levelled record ring.
// Uses wlrr_pkg, wlrr_cmd_if, wlrr_rsp_if and wlrr_store.
//
//   channel | direction | transaction carries
//   --------+-----------+-----------------------------------------------------------
//   cmd     | in        | action, temperature_tenths, pressure_tenths, sample_count
//   rsp     | out       | status, temperature_out, pressure_out, stored_total, last
//
// One command is in work at a time; cmd.ready is high only when the sequencer is idle.
// Every command first scans the count area through the store's single read port.
// A write then makes 6 store writes; a read fetches four bytes per returned record.
// Reset clears the per-byte valid flags at once, so the store reads erased at once.
// A stalled rsp only holds the sequencer when a further result is due; the final
// result of a command waits in the output register while the next command is taken.
module wear_leveled_record_ring_unit #(
    parameter int RECORD_SLOTS = wlrr_pkg::RECORD_SLOTS_DEF,
    parameter int STORE_BYTES  = wlrr_pkg::STORE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    wlrr_cmd_if.sink       cmd,
    wlrr_rsp_if.source     rsp
);

    localparam int AW = wlrr_pkg::ADDR_W;
    localparam int TW = wlrr_pkg::TOTAL_W;
    localparam int CL = 2 * RECORD_SLOTS;          // count-area length in bytes
    localparam int CW = $clog2(CL + 1);            // count-area offset, can hold CL
    localparam int SW = $clog2(RECORD_SLOTS);      // slot number

    localparam logic [AW-1:0] COUNT_BASE = AW'(4 * RECORD_SLOTS);
    localparam logic [CW-1:0] CL_END     = CW'(CL);
    localparam logic [CW-1:0] CL_LAST    = CW'(CL - 1);
    localparam logic [CW-1:0] RS_OFF     = CW'(RECORD_SLOTS);
    localparam logic [TW-1:0] RS_TOT     = TW'(RECORD_SLOTS);
    localparam logic [7:0]    RS_BYTE    = 8'(RECORD_SLOTS);
    localparam logic [SW-1:0] SLOT_LAST  = SW'(RECORD_SLOTS - 1);

    // sequencer
    wlrr_pkg::state_t    state_reg, state_next;
    wlrr_pkg::action_t   op_reg, op_next;
    logic [15:0]         temp_reg, temp_next;
    logic [15:0]         pres_reg, pres_next;
    logic [7:0]          want_reg, want_next;

    // count-area scan: one read issued and one checked per cycle
    logic [CW-1:0]       scan_off_reg, scan_off_next;
    logic [CW-1:0]       chk_off_reg, chk_off_next;
    logic                chk_vld_reg, chk_vld_next;

    logic [CW-1:0]       head_reg, head_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [TW-1:0]       total_reg, total_next;
    logic [TW-1:0]       remain_reg, remain_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [31:0]         rec_reg, rec_next;

    // output register
    logic                out_vld_reg, out_vld_next;
    wlrr_pkg::status_t   out_status_reg, out_status_next;
    logic [15:0]         out_temp_reg, out_temp_next;
    logic [15:0]         out_pres_reg, out_pres_next;
    logic [TW-1:0]       out_total_reg, out_total_next;
    logic                out_last_reg, out_last_next;

    // store access
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_data;
    wlrr_pkg::store_wr_t store_wr;

    // scan results
    logic                found;
    logic                exhausted;
    logic [CW-1:0]       h_sel;
    logic [TW-1:0]       tot_sel;
    logic [CW-1:0]       slot_full;
    logic [SW-1:0]       slot_sel;
    logic [TW-1:0]       nt_sel;
    logic [TW-1:0]       n_sel;
    logic [CW-1:0]       next_off;
    logic [AW-1:0]       slot_base;

    function automatic logic [SW-1:0] step_back(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s == '0) ? SLOT_LAST : s - SW'(1);
        return r;
    endfunction

    wlrr_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (store_wr)
    );

    // head is the first count byte that is not erased; all erased gives head 0, count 0
    assign found     = chk_vld_reg && (rd_data != wlrr_pkg::ERASED_BYTE);
    assign exhausted = chk_vld_reg && (chk_off_reg == CL_LAST) && !found;
    assign h_sel     = found ? chk_off_reg : '0;
    // a corrupt count above the slot total reads as full
    assign tot_sel   = !found ? '0 : ((rd_data > RS_BYTE) ? RS_TOT : rd_data[TW-1:0]);
    assign slot_full = (h_sel >= RS_OFF) ? h_sel - RS_OFF : h_sel;
    assign slot_sel  = slot_full[SW-1:0];
    assign nt_sel    = (tot_sel < RS_TOT) ? tot_sel + TW'(1) : RS_TOT;
    assign n_sel     = ({3'b000, tot_sel} < want_reg) ? tot_sel : want_reg[TW-1:0];
    assign next_off  = (head_reg == CL_LAST) ? '0 : head_reg + CW'(1);
    assign slot_base = AW'({slot_reg, 2'b00});

    assign cmd.ready = (state_reg == wlrr_pkg::S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        temp_next       = temp_reg;
        pres_next       = pres_reg;
        want_next       = want_reg;
        scan_off_next   = scan_off_reg;
        chk_off_next    = chk_off_reg;
        chk_vld_next    = 1'b0;
        head_next       = head_reg;
        slot_next       = slot_reg;
        total_next      = total_reg;
        remain_next     = remain_reg;
        cnt_next        = cnt_reg;
        rec_next        = rec_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_temp_next   = out_temp_reg;
        out_pres_next   = out_pres_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        rd_addr         = COUNT_BASE + AW'(scan_off_reg);
        store_wr        = '0;

        case (state_reg)
            wlrr_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next       = cmd.action;
                    temp_next     = cmd.temperature_tenths;
                    pres_next     = cmd.pressure_tenths;
                    want_next     = cmd.sample_count;
                    scan_off_next = '0;
                    state_next    = wlrr_pkg::S_SCAN;
                end
            end

            wlrr_pkg::S_SCAN:
            begin
                chk_off_next = scan_off_reg;
                chk_vld_next = (scan_off_reg != CL_END);
                if (scan_off_reg != CL_END)
                begin
                    scan_off_next = scan_off_reg + CW'(1);
                end
                if (found || exhausted)
                begin
                    chk_vld_next = 1'b0;
                    head_next    = h_sel;
                    slot_next    = slot_sel;
                    total_next   = tot_sel;
                    cnt_next     = '0;
                    case (op_reg)
                        wlrr_pkg::ACT_WRITE:
                        begin
                            total_next = nt_sel;
                            state_next = wlrr_pkg::S_WRITE;
                        end
                        wlrr_pkg::ACT_READ:
                        begin
                            remain_next = n_sel;
                            slot_next   = step_back(slot_sel);
                            state_next  = (n_sel == '0) ? wlrr_pkg::S_EMIT
                                                        : wlrr_pkg::S_FETCH;
                        end
                        wlrr_pkg::ACT_COUNT:
                        begin
                            state_next = wlrr_pkg::S_EMIT;
                        end
                        default:
                        begin
                            // erase: the store clears its valid flags, count reported as zero
                            store_wr.erase = 1'b1;
                            total_next     = '0;
                            state_next     = wlrr_pkg::S_EMIT;
                        end
                    endcase
                end
            end

            wlrr_pkg::S_WRITE:
            begin
                // record high byte first, then erase old count, then new count one on
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd0:
                    begin
                        store_wr = '{wr_en: 1'b1, erase: 1'b0, addr: slot_base,
                                     data: temp_reg[15:8]};
                    end
                    3'd1:
                    begin
                        store_wr = '{wr_en: 1'b1, erase: 1'b0, addr: slot_base + AW'(1),
                                     data: temp_reg[7:0]};
                    end
                    3'd2:
                    begin
                        store_wr = '{wr_en: 1'b1, erase: 1'b0, addr: slot_base + AW'(2),
                                     data: pres_reg[15:8]};
                    end
                    3'd3:
                    begin
                        store_wr = '{wr_en: 1'b1, erase: 1'b0, addr: slot_base + AW'(3),
                                     data: pres_reg[7:0]};
                    end
                    3'd4:
                    begin
                        store_wr = '{wr_en: 1'b1, erase: 1'b0,
                                     addr: COUNT_BASE + AW'(head_reg),
                                     data: wlrr_pkg::ERASED_BYTE};
                    end
                    3'd5:
                    begin
                        store_wr = '{wr_en: 1'b1, erase: 1'b0,
                                     addr: COUNT_BASE + AW'(next_off),
                                     data: 8'(total_reg)};
                        state_next = wlrr_pkg::S_EMIT;
                    end
                    default:
                    begin
                        state_next = wlrr_pkg::S_EMIT;
                    end
                endcase
            end

            wlrr_pkg::S_FETCH:
            begin
                // issue four byte reads, collect each in the cycle after it is issued
                rd_addr = slot_base + AW'(cnt_reg[1:0]);
                if (cnt_reg != 3'd0)
                begin
                    rec_next = {rec_reg[23:0], rd_data};
                end
                if (cnt_reg == 3'd4)
                begin
                    state_next = wlrr_pkg::S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            wlrr_pkg::S_EMIT:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next   = 1'b1;
                    out_temp_next  = '0;
                    out_pres_next  = '0;
                    out_total_next = total_reg;
                    out_last_next  = 1'b1;
                    state_next     = wlrr_pkg::S_IDLE;
                    case (op_reg)
                        wlrr_pkg::ACT_WRITE:
                        begin
                            out_status_next = wlrr_pkg::ST_WRITTEN;
                        end
                        wlrr_pkg::ACT_READ:
                        begin
                            if (remain_reg == '0)
                            begin
                                out_status_next = wlrr_pkg::ST_NO_SAMPLES;
                            end
                            else
                            begin
                                out_status_next = wlrr_pkg::ST_RECORD;
                                out_temp_next   = rec_reg[31:16];
                                out_pres_next   = rec_reg[15:0];
                                if (remain_reg != TW'(1))
                                begin
                                    out_last_next = 1'b0;
                                    remain_next   = remain_reg - TW'(1);
                                    slot_next     = step_back(slot_reg);
                                    cnt_next      = '0;
                                    state_next    = wlrr_pkg::S_FETCH;
                                end
                            end
                        end
                        wlrr_pkg::ACT_COUNT:
                        begin
                            out_status_next = wlrr_pkg::ST_COUNT;
                        end
                        default:
                        begin
                            out_status_next = wlrr_pkg::ST_ERASED;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = wlrr_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wlrr_pkg::S_IDLE;
            op_reg       <= wlrr_pkg::ACT_WRITE;
            scan_off_reg <= '0;
            chk_off_reg  <= '0;
            chk_vld_reg  <= 1'b0;
            remain_reg   <= '0;
            cnt_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            scan_off_reg <= scan_off_next;
            chk_off_reg  <= chk_off_next;
            chk_vld_reg  <= chk_vld_next;
            remain_reg   <= remain_next;
            cnt_reg      <= cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        temp_reg       <= temp_next;
        pres_reg       <= pres_next;
        want_reg       <= want_next;
        head_reg       <= head_next;
        slot_reg       <= slot_next;
        total_reg      <= total_next;
        rec_reg        <= rec_next;
        out_status_reg <= out_status_next;
        out_temp_reg   <= out_temp_next;
        out_pres_reg   <= out_pres_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.temperature_out = out_temp_reg;
    assign rsp.pressure_out    = out_pres_reg;
    assign rsp.stored_total    = out_total_reg;
    assign rsp.last            = out_last_reg;

`ifndef SYNTHESIS
    // a store write and an erase never share a cycle
    a_wr_erase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(store_wr.wr_en && store_wr.erase))
        else $error("store write and erase in the same cycle");

    // records still owed never exceed the ring size
    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= RS_TOT)
        else $error("remaining record count out of range");

    // the head located by the scan lies inside the count area
    a_head_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wlrr_pkg::S_WRITE) |-> (head_reg <= CL_LAST))
        else $error("head offset beyond count area");

    // only a record result can be followed by more results of the same command
    a_not_last_record: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (rsp.status == wlrr_pkg::ST_RECORD))
        else $error("non-final result that is not a record");
`endif

endmodule
